/* hw/rtl/cvs_pkg.sv */
package cvs_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 12;
    localparam int COEF_W    = 8;
    localparam int KROW_W    = 3 * COEF_W;
    localparam int SUM_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = KROW_W;

    // Smallest frame dimension in use
    localparam int MIN_DIM = 3;

    // Product of an unsigned pixel and a signed coefficient
    localparam int PROD_W = PIX_W + COEF_W + 1;
    // Sum of one kernel row, then of all three rows
    localparam int RSUM_W = PROD_W + 2;
    localparam int TSUM_W = RSUM_W + 2;

    // Line memory entry: row r-2 in the low byte, row r-1 in the high byte
    localparam int ENTRY_W = 2 * PIX_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH       = 3'd0,
        REG_IMAGE_HEIGHT      = 3'd1,
        REG_KERNEL_ROW_TOP    = 3'd2,
        REG_KERNEL_ROW_MIDDLE = 3'd3,
        REG_KERNEL_ROW_BOTTOM = 3'd4
    } cfg_reg_t;

    // 3x3 window, row-major, index row*3 + column
    typedef logic [8:0][PIX_W-1:0] window_t;

    // Three kernel rows, each with column 0 in its low byte
    typedef logic [2:0][KROW_W-1:0] kernel_t;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RSUM_W-1:0] rsum_t;

    // Per-pixel tag carried down the pipeline
    typedef struct packed {
        logic produce;
        logic last;
    } tag_t;

endpackage

/* hw/rtl/conv3x3_valid_stream_top.sv */
// Streaming 3x3 valid-mode convolution over 8-bit raster pixels.
// A result passes the window stage register, then the product, row-sum and output
// registers. Throughput: one pixel per cycle while the output is not stalled; the line
// memory is read at accept and written back as the pixel leaves the window stage, one entry per pixel.
// Reset clears counters, pipeline valids, window and registers to defaults;
// the line memory is not cleared and is filled by the first two rows.
module conv3x3_valid_stream_top #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [cvs_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [cvs_pkg::CFG_W-1:0]       cfg_wr_data,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] pixel
    // convolution output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,    // [19:0] conv_sum, [23:20] zero
    output logic                            m_tlast     // last_of_frame
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers
    logic [cvs_pkg::COL_W-1:0]  width_reg;
    logic [cvs_pkg::ROW_W-1:0]  height_reg;
    cvs_pkg::kernel_t           kernel_reg;

    // Position counters
    logic [cvs_pkg::COL_W-1:0]  col_reg;
    logic [cvs_pkg::ROW_W-1:0]  row_reg;

    logic [cvs_pkg::COL_W-1:0]  width_use;
    logic [cvs_pkg::COL_W-1:0]  width_last;
    logic [cvs_pkg::ROW_W-1:0]  height_use;
    logic [cvs_pkg::ROW_W-1:0]  height_last;
    logic                       row_end;
    logic                       frame_end;
    logic                       accept;
    cvs_pkg::tag_t              acc_tag;
    logic [ADDR_W-1:0]          acc_addr;

    logic [cvs_pkg::ENTRY_W-1:0] rd_data;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [cvs_pkg::ENTRY_W-1:0] wr_data;

    logic                        s1_ready;
    logic                        win_valid;
    logic                        win_last;
    cvs_pkg::window_t            win_next;
    logic                        mac_ready;
    logic [cvs_pkg::SUM_W-1:0]   m_sum;

    // Decode configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cvs_pkg::COL_W'(5);
            height_reg <= cvs_pkg::ROW_W'(5);
            kernel_reg <= {3{24'h010101}};
        end else if (cfg_wr_en) begin
            unique case (cvs_pkg::cfg_reg_t'(cfg_wr_index))
                cvs_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wr_data[cvs_pkg::COL_W-1:0];
                end
                cvs_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wr_data[cvs_pkg::ROW_W-1:0];
                end
                cvs_pkg::REG_KERNEL_ROW_TOP: begin
                    kernel_reg[0] <= cfg_wr_data;
                end
                cvs_pkg::REG_KERNEL_ROW_MIDDLE: begin
                    kernel_reg[1] <= cfg_wr_data;
                end
                cvs_pkg::REG_KERNEL_ROW_BOTTOM: begin
                    kernel_reg[2] <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame size in use
    always_comb begin
        if (width_reg < cvs_pkg::COL_W'(cvs_pkg::MIN_DIM)) begin
            width_use = cvs_pkg::COL_W'(cvs_pkg::MIN_DIM);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            width_use = cvs_pkg::COL_W'(MAX_WIDTH);
        end else begin
            width_use = width_reg;
        end
        if (height_reg < cvs_pkg::ROW_W'(cvs_pkg::MIN_DIM)) begin
            height_use = cvs_pkg::ROW_W'(cvs_pkg::MIN_DIM);
        end else begin
            height_use = height_reg;
        end
    end

    assign width_last  = width_use - 1'b1;
    assign height_last = height_use - 1'b1;
    assign row_end     = col_reg >= width_last;
    assign frame_end   = row_end && (row_reg >= height_last);

    assign accept          = s_tvalid && s_tready;
    assign s_tready        = s1_ready;
    assign acc_addr        = ADDR_W'(col_reg);
    assign acc_tag.produce = (row_reg >= cvs_pkg::ROW_W'(2)) &&
                             (col_reg >= cvs_pkg::COL_W'(2));
    assign acc_tag.last    = frame_end;

    // Advance the raster position on each accepted pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    cvs_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (acc_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    cvs_window #(
        .ADDR_W (ADDR_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc       (accept),
        .acc_pixel (s_tdata),
        .acc_addr  (acc_addr),
        .acc_tag   (acc_tag),
        .s1_ready  (s1_ready),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .ready_dn  (mac_ready),
        .win_valid (win_valid),
        .win_last  (win_last),
        .win_next  (win_next)
    );

    cvs_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (win_valid),
        .in_last  (win_last),
        .window   (win_next),
        .kernel   (kernel_reg),
        .in_ready (mac_ready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_sum    (m_sum),
        .m_last   (m_tlast)
    );

    assign m_tdata = {4'b0, m_sum};

    // The column never leaves the line memory
    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (int'(col_reg) < MAX_WIDTH))
        else $error("column outside line memory");

    // A read never meets the write-back of the same entry
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && wr_en) |-> (acc_addr != wr_addr))
        else $error("line memory read and write collide");

    // The frame end returns both counters to the origin
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && frame_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared at frame end");

    // The frame end is flagged only on the last pixel of a row
    a_win_tagged: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (acc_tag.last == 1'b0 || row_end))
        else $error("frame end flagged inside a row");

endmodule

/* hw/rtl/cvs_line_mem.sv */
module cvs_line_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [cvs_pkg::ENTRY_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [cvs_pkg::ENTRY_W-1:0] wr_data
);

    logic [cvs_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [cvs_pkg::ENTRY_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no new request is read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/cvs_window.sv */
module cvs_window #(
    parameter int ADDR_W = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // accepted pixel
    input  logic                        acc,
    input  logic [cvs_pkg::PIX_W-1:0]   acc_pixel,
    input  logic [ADDR_W-1:0]           acc_addr,
    input  cvs_pkg::tag_t               acc_tag,
    output logic                        s1_ready,
    // line memory
    input  logic [cvs_pkg::ENTRY_W-1:0] rd_data,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [cvs_pkg::ENTRY_W-1:0] wr_data,
    // window toward the multipliers
    input  logic                        ready_dn,
    output logic                        win_valid,
    output logic                        win_last,
    output cvs_pkg::window_t            win_next
);

    logic                      valid1_reg;
    logic [cvs_pkg::PIX_W-1:0] pix1_reg;
    logic [ADDR_W-1:0]         addr1_reg;
    cvs_pkg::tag_t             tag1_reg;
    cvs_pkg::window_t          window_reg;

    logic                      retire;
    logic [cvs_pkg::PIX_W-1:0] up_pix;
    logic [cvs_pkg::PIX_W-1:0] lo_pix;

    // A pixel with no result retires without waiting on the multipliers
    assign retire   = valid1_reg && (!tag1_reg.produce || ready_dn);
    assign s1_ready = !valid1_reg || retire;

    assign up_pix = rd_data[cvs_pkg::PIX_W-1:0];
    assign lo_pix = rd_data[cvs_pkg::ENTRY_W-1:cvs_pkg::PIX_W];

    // Shift the window left and bring in the new right column
    always_comb begin
        win_next = window_reg;
        for (int i = 0; i < 3; i++) begin
            win_next[i*3+0] = window_reg[i*3+1];
            win_next[i*3+1] = window_reg[i*3+2];
        end
        win_next[2] = up_pix;
        win_next[5] = lo_pix;
        win_next[8] = pix1_reg;
    end

    // Write back: row r-1 moves up, the new pixel becomes row r-1
    assign wr_en   = retire;
    assign wr_addr = addr1_reg;
    assign wr_data = {pix1_reg, lo_pix};

    assign win_valid = retire && tag1_reg.produce;
    assign win_last  = tag1_reg.last;

    // Stage valid and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            window_reg <= '0;
        end else begin
            if (s1_ready) begin
                valid1_reg <= acc;
            end
            if (retire) begin
                window_reg <= win_next;
            end
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (acc) begin
            pix1_reg  <= acc_pixel;
            addr1_reg <= acc_addr;
            tag1_reg  <= acc_tag;
        end
    end

endmodule

/* hw/rtl/cvs_mac.sv */
module cvs_mac (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic                      in_last,
    input  cvs_pkg::window_t          window,
    input  cvs_pkg::kernel_t          kernel,
    output logic                      in_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [cvs_pkg::SUM_W-1:0] m_sum,
    output logic                      m_last
);

    logic                        v2_reg;
    logic                        last2_reg;
    cvs_pkg::prod_t [8:0]        prod2_reg;
    cvs_pkg::prod_t [8:0]        prod_next;

    logic                        v3_reg;
    logic                        last3_reg;
    cvs_pkg::rsum_t [2:0]        rsum3_reg;
    cvs_pkg::rsum_t [2:0]        rsum_next;

    logic                        m_valid_reg;
    logic                        m_last_reg;
    logic [cvs_pkg::SUM_W-1:0]   m_sum_reg;
    logic signed [cvs_pkg::TSUM_W-1:0] tsum_next;

    logic ready_out;
    logic ready3;
    logic ready2;

    assign ready_out = !m_valid_reg || m_ready;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign in_ready  = ready2;

    // Nine pixel by coefficient products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i*3+j] =
                    $signed({1'b0, window[i*3+j]}) *
                    $signed(kernel[i][j*cvs_pkg::COEF_W +: cvs_pkg::COEF_W]);
            end
        end
    end

    // Sum each kernel row
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum_next[i] = cvs_pkg::RSUM_W'(prod2_reg[i*3+0])
                         + cvs_pkg::RSUM_W'(prod2_reg[i*3+1])
                         + cvs_pkg::RSUM_W'(prod2_reg[i*3+2]);
        end
    end

    // Sum the three rows
    assign tsum_next = cvs_pkg::TSUM_W'(rsum3_reg[0])
                     + cvs_pkg::TSUM_W'(rsum3_reg[1])
                     + cvs_pkg::TSUM_W'(rsum3_reg[2]);

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ready2) begin
                v2_reg <= in_valid;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
            if (ready_out) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // Stage payloads, advanced only with a valid request
    always_ff @(posedge aclk) begin
        if (in_valid && ready2) begin
            prod2_reg <= prod_next;
            last2_reg <= in_last;
        end
        if (v2_reg && ready3) begin
            rsum3_reg <= rsum_next;
            last3_reg <= last2_reg;
        end
        if (v3_reg && ready_out) begin
            m_sum_reg  <= tsum_next[cvs_pkg::SUM_W-1:0];
            m_last_reg <= last3_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sum   = m_sum_reg;
    assign m_last  = m_last_reg;

endmodule
